/* src/bsmc_pkg.sv */
package bsmc_pkg;

    localparam int MAX_BONES   = 256;
    localparam int WORLD_WORDS = 12;
    localparam int WORLD_DEPTH = MAX_BONES * WORLD_WORDS;
    localparam int WORLD_AW    = $clog2(WORLD_DEPTH);

    localparam int IN_W  = 280;
    localparam int OUT_W = 144;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    localparam logic [1:0] ROW_LAST = 2'd2;
    localparam logic [1:0] ROW_NONE = 2'd3;

    localparam logic [2:0] CFG_ROOT_R0_C01 = 3'd0;
    localparam logic [2:0] CFG_ROOT_R0_C23 = 3'd1;
    localparam logic [2:0] CFG_ROOT_R1_C01 = 3'd2;
    localparam logic [2:0] CFG_ROOT_R1_C23 = 3'd3;
    localparam logic [2:0] CFG_ROOT_R2_C01 = 3'd4;
    localparam logic [2:0] CFG_ROOT_R2_C23 = 3'd5;

    typedef logic [31:0] t_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MAC1,
        S_STORE,
        S_MAC2,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_word mul_a;
        t_word mul_b;
        t_word add_a;
        t_word add_b;
    } t_fpu_req;

    typedef struct packed {
        t_word mul_y;
        t_word add_y;
    } t_fpu_rsp;

endpackage

/* src/bsmc_world_ram.sv */
module bsmc_world_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [bsmc_pkg::WORLD_AW-1:0] i_waddr,
    input  bsmc_pkg::t_word               i_wdata,
    input  logic [bsmc_pkg::WORLD_AW-1:0] i_raddr,
    output bsmc_pkg::t_word               o_rdata
);
    import bsmc_pkg::*;

    t_word r_mem [WORLD_DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bsmc_fpu.sv */
module bsmc_fpu (
    input  bsmc_pkg::t_fpu_req i_req,
    output bsmc_pkg::t_fpu_rsp o_rsp
);
    import bsmc_pkg::*;

    // value = p * 2^e, p nonzero; round to nearest even, subnormals kept
    function automatic t_word f_round(logic sgn, logic [47:0] p, logic signed [11:0] e);
        logic [5:0]         pos;
        logic [47:0]        pn;
        logic signed [12:0] be;
        logic [95:0]        u;
        logic [6:0]         sh;
        logic [30:0]        mag;
        logic               up;
        t_word              res;
        pos = '0;
        for (int i = 0; i < 48; i++) begin
            if (p[i]) begin
                pos = 6'(i);
            end
        end
        pn = p << (6'd47 - pos);
        be = 13'(e) + 13'sd127 + $signed({7'b0, pos});
        u  = '0;
        sh = '0;
        if (be >= 13'sd255) begin
            res = {sgn, 8'hFF, 23'b0};
        end else if (be >= 13'sd1) begin
            mag = {be[7:0], pn[46:24]};
            up  = pn[23] & ((|pn[22:0]) | pn[24]);
            res = {sgn, mag + 31'(up)};
        end else begin
            sh  = (be < -13'sd62) ? 7'd63 : 7'(13'sd1 - be);
            u   = {pn, 48'b0} >> sh;
            mag = {8'b0, u[94:72]};
            up  = u[71] & ((|u[70:0]) | u[72]);
            res = {sgn, mag + 31'(up)};
        end
        return res;
    endfunction

    function automatic t_word f_mul(t_word a, t_word b);
        logic               s, na, nb, ia, ib, za, zb;
        logic [7:0]         ea, eb;
        logic [23:0]        ma, mb;
        logic signed [11:0] e;
        t_word              res;
        s  = a[31] ^ b[31];
        na = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nb = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        ia = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        ib = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        za = (a[30:0] == '0);
        zb = (b[30:0] == '0);
        ea = (a[30:23] == '0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == '0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != '0, a[22:0]};
        mb = {b[30:23] != '0, b[22:0]};
        e  = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd300;
        if (na || nb || (ia && zb) || (za && ib)) begin
            res = QNAN;
        end else if (ia || ib) begin
            res = {s, 8'hFF, 23'b0};
        end else if (za || zb) begin
            res = {s, 31'b0};
        end else begin
            res = f_round(s, ma * mb, e);
        end
        return res;
    endfunction

    function automatic t_word f_add(t_word a, t_word b);
        logic               na, nb, ia, ib, swp, sx, sy;
        t_word              x, y;
        logic [7:0]         ex, ey, d;
        logic [4:0]         dd;
        logic [23:0]        mx, my;
        logic [53:0]        w;
        logic [26:0]        ax, ay;
        logic [27:0]        sum;
        logic signed [11:0] e;
        t_word              res;
        na  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        nb  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        ia  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
        ib  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
        swp = (b[30:0] > a[30:0]);
        x   = swp ? b : a;
        y   = swp ? a : b;
        sx  = x[31];
        sy  = y[31];
        ex  = (x[30:23] == '0) ? 8'd1 : x[30:23];
        ey  = (y[30:23] == '0) ? 8'd1 : y[30:23];
        mx  = {x[30:23] != '0, x[22:0]};
        my  = {y[30:23] != '0, y[22:0]};
        d   = ex - ey;
        dd  = (d > 8'd26) ? 5'd27 : d[4:0];
        w   = {my, 3'b0, 27'b0} >> dd;
        ax  = {mx, 3'b0};
        ay  = {w[53:28], w[27] | (|w[26:0])};
        sum = (sx == sy) ? ({1'b0, ax} + {1'b0, ay}) : ({1'b0, ax} - {1'b0, ay});
        e   = $signed({4'b0, ex}) - 12'sd173;
        if (na || nb || (ia && ib && (a[31] != b[31]))) begin
            res = QNAN;
        end else if (ia) begin
            res = a;
        end else if (ib) begin
            res = b;
        end else if (sum == '0) begin
            res = {a[31] & b[31], 31'b0};
        end else begin
            res = f_round(sx, {sum, 20'b0}, e);
        end
        return res;
    endfunction

    assign o_rsp.mul_y = f_mul(i_req.mul_a, i_req.mul_b);
    assign o_rsp.add_y = f_add(i_req.add_a, i_req.add_b);

endmodule

/* src/bone_skinning_matrix_composer.sv */
// Flow: a row 0 or 1 beat is absorbed while idle; a row 2 beat starts a bone, which runs
// through a parent fetch from the world RAM (skipped with a root parent), 24 elements
// of 4 or 5 steps on the shared multiplier and adder, a world store and the load of the
// output register with its first output beat; the other 2 beats follow.
// A new bone is taken only after the last output beat of the previous one is loaded, as the
// single multiply/add pair serves it. Reset (synchronous, i_rst_n low): idle, no output, root = identity.
module bone_skinning_matrix_composer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: bone[7:0], parent_bone[16:8], row_number[18:17], local_c01[82:19],
    //        local_c23[146:83], invbind_c01[210:147], invbind_c23[274:211], zero pad
    input  logic [bsmc_pkg::IN_W-1:0]     i_s_axis_tdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: out_bone[7:0], out_row[9:8], skin_c01[73:10], skin_c23[137:74], zero pad
    output logic [bsmc_pkg::OUT_W-1:0]    o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [63:0]                   i_cfg_data
);
    import bsmc_pkg::*;

    t_state r_state, n_state;

    // input beat fields
    logic [7:0]  w_bone;
    logic [8:0]  w_parent;
    logic [1:0]  w_row;
    logic [63:0] w_l01, w_l23, w_i01, w_i23;
    logic        w_acc, w_par_ok;

    assign w_bone   = i_s_axis_tdata[7:0];
    assign w_parent = i_s_axis_tdata[16:8];
    assign w_row    = i_s_axis_tdata[18:17];
    assign w_l01    = i_s_axis_tdata[82:19];
    assign w_l23    = i_s_axis_tdata[146:83];
    assign w_i01    = i_s_axis_tdata[210:147];
    assign w_i23    = i_s_axis_tdata[274:211];

    assign w_acc    = i_s_axis_tvalid && o_s_axis_tready;
    // parent must be non-negative, in the store and already composed
    assign w_par_ok = !w_parent[8] && (w_parent[7:0] < w_bone) &&
                      (32'(w_parent[7:0]) < MAX_BONES);

    logic [63:0] r_root [6];
    t_word       r_loc   [12];
    t_word       r_inv   [12];
    t_word       r_par   [12];
    t_word       r_world [12];
    t_word       r_skin  [12];

    logic [7:0]  r_bone, r_pidx;
    logic [3:0]  r_elem, r_cnt;
    logic [2:0]  r_step;
    t_word       r_p0, r_p1, r_p2, r_s;

    logic              r_out_valid, r_out_last;
    logic [OUT_W-1:0]  r_out_data;

    // MAC operand selection: A is parent (phase 1) or world (phase 2),
    // B is local (phase 1) or inverse bind (phase 2)
    logic       w_ph2;
    logic [1:0] w_r, w_k, w_j;
    t_word      w_a_j, w_a_3, w_b_j;
    t_fpu_req   w_req;
    t_fpu_rsp   w_rsp;
    logic       w_mac, w_mac_done, w_out_load, w_ram_we, w_store_en;
    t_word      w_rdata;
    logic [WORLD_AW-1:0] w_raddr, w_waddr;

    assign w_ph2 = (r_state == S_MAC2);
    assign w_r   = r_elem[3:2];
    assign w_k   = r_elem[1:0];
    assign w_j   = r_step[1:0];
    assign w_a_j = w_ph2 ? r_world[{w_r, w_j}] : r_par[{w_r, w_j}];
    assign w_a_3 = w_ph2 ? r_world[{w_r, 2'd3}] : r_par[{w_r, 2'd3}];
    assign w_b_j = w_ph2 ? r_inv[{w_j, w_k}] : r_loc[{w_j, w_k}];

    always_comb begin
        w_req.mul_a = w_a_j;
        w_req.mul_b = w_b_j;
        case (r_step)
            3'd2:    begin w_req.add_a = r_p0; w_req.add_b = r_p1; end
            3'd3:    begin w_req.add_a = r_s;  w_req.add_b = r_p2; end
            default: begin w_req.add_a = r_s;  w_req.add_b = w_a_3; end
        endcase
    end

    bsmc_fpu u_fpu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_raddr = WORLD_AW'(32'(r_pidx) * WORLD_WORDS + 32'(r_cnt));
    assign w_waddr = WORLD_AW'(32'(r_bone) * WORLD_WORDS + 32'(r_cnt));
    assign w_store_en = (32'(r_bone) < MAX_BONES);

    bsmc_world_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (r_world[r_cnt]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // next state and strobes
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_mac           = 1'b0;
        w_mac_done      = 1'b0;
        w_ram_we        = 1'b0;
        w_out_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (w_acc && (w_row == ROW_LAST)) begin
                    n_state = w_par_ok ? S_LOAD : S_MAC1;
                end
            end
            S_LOAD: begin
                if (r_cnt == 4'd12) begin
                    n_state = S_MAC1;
                end
            end
            S_MAC1, S_MAC2: begin
                w_mac      = 1'b1;
                w_mac_done = (r_step == 3'd4) || ((r_step == 3'd3) && (w_k != 2'd3));
                if (w_mac_done && (r_elem == 4'd11)) begin
                    if (r_state == S_MAC2) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = w_store_en ? S_STORE : S_MAC2;
                    end
                end
            end
            S_STORE: begin
                w_ram_we = 1'b1;
                if (r_cnt == 4'd11) begin
                    n_state = S_MAC2;
                end
            end
            S_EMIT: begin
                w_out_load = !r_out_valid || i_m_axis_tready;
                if (w_out_load && (r_cnt == 4'd2)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_elem      <= '0;
            r_step      <= '0;
            r_root[0]   <= 64'h0000_0000_3F80_0000;
            r_root[1]   <= 64'h0;
            r_root[2]   <= 64'h3F80_0000_0000_0000;
            r_root[3]   <= 64'h0;
            r_root[4]   <= 64'h0;
            r_root[5]   <= 64'h0000_0000_3F80_0000;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROOT_R0_C01: r_root[0] <= i_cfg_data;
                    CFG_ROOT_R0_C23: r_root[1] <= i_cfg_data;
                    CFG_ROOT_R1_C01: r_root[2] <= i_cfg_data;
                    CFG_ROOT_R1_C23: r_root[3] <= i_cfg_data;
                    CFG_ROOT_R2_C01: r_root[4] <= i_cfg_data;
                    CFG_ROOT_R2_C23: r_root[5] <= i_cfg_data;
                    default: ;
                endcase
            end

            // sequencing counters
            if (r_state != n_state) begin
                r_cnt  <= '0;
                r_elem <= '0;
                r_step <= '0;
            end else if (w_mac) begin
                if (w_mac_done) begin
                    r_step <= '0;
                    r_elem <= r_elem + 4'd1;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end else if ((r_state == S_LOAD) || (r_state == S_STORE) || w_out_load) begin
                r_cnt <= r_cnt + 4'd1;
            end

            // output register
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc && (w_row != ROW_NONE)) begin
            r_loc[{w_row, 2'd0}] <= w_l01[31:0];
            r_loc[{w_row, 2'd1}] <= w_l01[63:32];
            r_loc[{w_row, 2'd2}] <= w_l23[31:0];
            r_loc[{w_row, 2'd3}] <= w_l23[63:32];
            r_inv[{w_row, 2'd0}] <= w_i01[31:0];
            r_inv[{w_row, 2'd1}] <= w_i01[63:32];
            r_inv[{w_row, 2'd2}] <= w_i23[31:0];
            r_inv[{w_row, 2'd3}] <= w_i23[63:32];
        end
        if (w_acc && (w_row == ROW_LAST)) begin
            r_bone <= w_bone;
            r_pidx <= w_parent[7:0];
            if (!w_par_ok) begin
                for (int r = 0; r < 3; r++) begin
                    r_par[r*4]   <= r_root[r*2][31:0];
                    r_par[r*4+1] <= r_root[r*2][63:32];
                    r_par[r*4+2] <= r_root[r*2+1][31:0];
                    r_par[r*4+3] <= r_root[r*2+1][63:32];
                end
            end
        end
        // RAM data is registered and lands in the cycle after its address
        if ((r_state == S_LOAD) && (r_cnt != 4'd0)) begin
            r_par[r_cnt - 4'd1] <= w_rdata;
        end

        if (w_mac) begin
            case (r_step)
                3'd0:    r_p0 <= w_rsp.mul_y;
                3'd1:    r_p1 <= w_rsp.mul_y;
                3'd2:    begin r_p2 <= w_rsp.mul_y; r_s <= w_rsp.add_y; end
                default: r_s <= w_rsp.add_y;
            endcase
            if (w_mac_done) begin
                if (w_ph2) begin
                    r_skin[r_elem] <= w_rsp.add_y;
                end else begin
                    r_world[r_elem] <= w_rsp.add_y;
                end
            end
        end

        if (w_out_load) begin
            r_out_data <= {6'b0,
                           r_skin[{r_cnt[1:0], 2'd3}], r_skin[{r_cnt[1:0], 2'd2}],
                           r_skin[{r_cnt[1:0], 2'd1}], r_skin[{r_cnt[1:0], 2'd0}],
                           r_cnt[1:0], r_bone};
            r_out_last <= (r_cnt[1:0] == ROW_LAST);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

/* src/bsmc_checker.sv */
module bsmc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic [bsmc_pkg::OUT_W-1:0] o_m_axis_tdata,
    input logic                       o_m_axis_tlast,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready
);
    import bsmc_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output beat valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output beat changed");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[9:8] == ROW_LAST)))
        else $error("tlast does not match row 2");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[9:8] != ROW_NONE))
        else $error("output row out of range");

endmodule

bind bone_skinning_matrix_composer bsmc_checker u_bsmc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);
